>>> rtl/core/pms_pkg.sv
package pms_pkg;

    // field widths of the tick and result words and of the registers
    localparam int TIME_W   = 32;
    localparam int WIDTH_W  = 12;
    localparam int OUT_W    = 12;
    localparam int STEP_W   = 8;
    localparam int MS_W     = 16;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_VIEW_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_PIXELS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_INTERVAL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_PAUSE    = 2'd3;

    // register values after reset
    localparam logic [WIDTH_W-1:0] VIEW_WIDTH_RST    = 12'd128;
    localparam logic [STEP_W-1:0]  STEP_PIXELS_RST   = 8'd3;
    localparam logic [MS_W-1:0]    STEP_INTERVAL_RST = 16'd360;
    localparam logic [MS_W-1:0]    END_PAUSE_RST     = 16'd1000;

    typedef struct packed {
        logic [TIME_W-1:0]  now_ms;
        logic               text_changed;
        logic [WIDTH_W-1:0] text_width;
    } t_tick;

endpackage

>>> rtl/core/pms_tick_if.sv
interface pms_tick_if;
    import pms_pkg::*;

    logic               valid;
    logic               ready;
    logic [TIME_W-1:0]  now_ms;
    logic               text_changed;
    logic [WIDTH_W-1:0] text_width;

    modport source (output valid, output now_ms, output text_changed, output text_width,
                    input ready);
    modport sink (input valid, input now_ms, input text_changed, input text_width,
                  output ready);
endinterface

>>> rtl/core/pms_result_if.sv
interface pms_result_if;
    import pms_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] scroll_offset;
    logic             moving;
    logic             backward;

    modport source (output valid, output scroll_offset, output moving, output backward,
                    input ready);
    modport sink (input valid, input scroll_offset, input moving, input backward,
                  output ready);
endinterface

>>> rtl/core/pingpong_marquee_scroller_unit.sv
// Ping-pong marquee scroller. Each tick word (time in ms, text-changed flag, text width)
// yields exactly one result word: the scroll offset, whether the text is moving, and
// whether the next move goes back toward zero. A tick is captured in an input register
// and resolved into the scroll state, which also serves as the result register, once
// the result slot is free; a new tick is taken every clock cycle while results are drained,
// so throughput is one word per cycle. All time compares use wrap-safe signed 32-bit
// differences. The user must write configuration through the plain write port only while
// no tick is in flight; the block itself does not enforce this.
module pingpong_marquee_scroller_unit #(
    parameter int OFFSET_BITS = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pms_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pms_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    pms_tick_if.sink                         i_tick,
    pms_result_if.source                     o_res
);
    import pms_pkg::*;

    // compare width: holds offset + step and the clamped overflow without loss
    localparam int CW = ((OFFSET_BITS > WIDTH_W) ? OFFSET_BITS : WIDTH_W) + 1;
    localparam logic [CW-1:0] OFF_MAX = CW'((33'd1 << OFFSET_BITS) - 33'd1);

    // configuration registers
    logic [WIDTH_W-1:0] r_view_width;
    logic [STEP_W-1:0]  r_step_pixels;
    logic [MS_W-1:0]    r_step_interval;
    logic [MS_W-1:0]    r_end_pause;

    // input stage
    logic  r_in_vld;
    t_tick r_in;

    // scroll state, doubles as the result register
    logic                   r_out_vld;
    logic [OFFSET_BITS-1:0] r_offset, n_offset;
    logic                   r_scrolling, n_scrolling;
    logic                   r_reversing, n_reversing;
    logic [TIME_W-1:0]      r_deadline, n_deadline;
    logic [TIME_W-1:0]      r_last_step, n_last_step;

    logic              out_adv;
    logic              in_ready;
    logic              fits;
    logic [CW-1:0]     ov_raw;
    logic [CW-1:0]     overflow;
    logic [CW-1:0]     off_ext;
    logic [CW-1:0]     step_ext;
    logic [CW-1:0]     next_fwd;
    logic [TIME_W-1:0] pause_diff;
    logic [TIME_W-1:0] eff_last;
    logic [TIME_W-1:0] step_diff;
    logic              step_due;
    logic [TIME_W-1:0] new_deadline;

    // handshake: result slot frees when taken, input slot when it moves on
    assign out_adv  = !r_out_vld || o_res.ready;
    assign in_ready = !r_in_vld || out_adv;
    assign i_tick.ready = in_ready;

    assign o_res.valid         = r_out_vld;
    assign o_res.scroll_offset = OUT_W'(r_offset);
    assign o_res.moving        = r_scrolling;
    assign o_res.backward      = r_reversing;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_width    <= VIEW_WIDTH_RST;
            r_step_pixels   <= STEP_PIXELS_RST;
            r_step_interval <= STEP_INTERVAL_RST;
            r_end_pause     <= END_PAUSE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_VIEW_WIDTH:    r_view_width    <= i_cfg_data[WIDTH_W-1:0];
                REG_STEP_PIXELS:   r_step_pixels   <= i_cfg_data[STEP_W-1:0];
                REG_STEP_INTERVAL: r_step_interval <= i_cfg_data[MS_W-1:0];
                REG_END_PAUSE:     r_end_pause     <= i_cfg_data[MS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_ready) begin
            r_in_vld <= i_tick.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_tick.valid) begin
            r_in.now_ms       <= i_tick.now_ms;
            r_in.text_changed <= i_tick.text_changed;
            r_in.text_width   <= i_tick.text_width;
        end
    end

    // overflow of the text past the view, clamped to the offset range
    assign fits     = r_in.text_width <= r_view_width;
    assign ov_raw   = CW'(r_in.text_width) - CW'(r_view_width);
    assign overflow = (ov_raw > OFF_MAX) ? OFF_MAX : ov_raw;
    assign off_ext  = CW'(r_offset);
    assign step_ext = CW'(r_step_pixels);
    assign next_fwd = off_ext + step_ext;

    // wrap-safe timing
    assign pause_diff   = r_in.now_ms - r_deadline;
    assign eff_last     = r_scrolling ? r_last_step : r_in.now_ms;
    assign step_diff    = r_in.now_ms - eff_last;
    assign step_due     = !step_diff[TIME_W-1] && (step_diff >= TIME_W'(r_step_interval));
    assign new_deadline = r_in.now_ms + TIME_W'(r_end_pause);

    // next scroll state for the word in the input stage
    always_comb begin
        n_offset    = r_offset;
        n_scrolling = r_scrolling;
        n_reversing = r_reversing;
        n_deadline  = r_deadline;
        n_last_step = r_last_step;
        if (r_in.text_changed) begin
            n_offset    = '0;
            n_scrolling = 1'b0;
            n_reversing = 1'b0;
            n_deadline  = new_deadline;
        end else if (fits) begin
            n_offset = '0;
        end else if (r_scrolling || !pause_diff[TIME_W-1]) begin
            n_scrolling = 1'b1;
            n_last_step = eff_last;
            if (step_due) begin
                n_last_step = r_in.now_ms;
                if (r_reversing) begin
                    if (off_ext <= step_ext) begin
                        n_offset    = '0;
                        n_scrolling = 1'b0;
                        n_reversing = 1'b0;
                        n_deadline  = new_deadline;
                    end else begin
                        n_offset = OFFSET_BITS'(off_ext - step_ext);
                    end
                end else if (next_fwd >= overflow) begin
                    n_offset    = OFFSET_BITS'(overflow);
                    n_scrolling = 1'b0;
                    n_reversing = 1'b1;
                    n_deadline  = new_deadline;
                end else begin
                    n_offset = OFFSET_BITS'(next_fwd);
                end
            end
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    // scroll state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset    <= '0;
            r_scrolling <= 1'b0;
            r_reversing <= 1'b0;
            r_deadline  <= '0;
            r_last_step <= '0;
        end else if (out_adv && r_in_vld) begin
            r_offset    <= n_offset;
            r_scrolling <= n_scrolling;
            r_reversing <= n_reversing;
            r_deadline  <= n_deadline;
            r_last_step <= n_last_step;
        end
    end

    // a text change always restarts from a still, forward, zero position
    a_change_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_adv && r_in_vld && r_in.text_changed) |=>
        (r_offset == '0 && !r_scrolling && !r_reversing && r_out_vld))
        else $error("text change did not clear the scroll state");

    // state only moves when a word is resolved into the result slot
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(out_adv && r_in_vld) |=>
        ($stable(r_offset) && $stable(r_scrolling) && $stable(r_reversing)))
        else $error("scroll state changed without a word");

    // a full input stage behind a blocked result must stall the input
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !out_adv) |-> !i_tick.ready)
        else $error("input taken while pipeline blocked");

endmodule

>>> dv/marquee_checker.sv
module marquee_checker #(
    parameter int OFFSET_BITS = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pms_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pms_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pms_tick_if                            i_tick_mon,
    pms_result_if                          i_res_mon,
    output int                             o_fail_count,
    output int                             o_pending
);
    import pms_pkg::*;

    localparam logic [31:0] POS_MAX = (32'd1 << OFFSET_BITS) - 32'd1;
    localparam int REPORT_CAP = 20;

    typedef struct packed {
        logic [OUT_W-1:0] scroll_offset;
        logic             moving;
        logic             backward;
    } t_scroll_view;

    // shadow copy of the registers
    logic [WIDTH_W-1:0] view_w;
    logic [STEP_W-1:0]  step_px;
    logic [MS_W-1:0]    interval_ms;
    logic [MS_W-1:0]    pause_ms;

    // shadow copy of the scroll state
    logic [OFFSET_BITS-1:0] pos;
    logic                   running;
    logic                   rev;
    logic [TIME_W-1:0]      deadline;
    logic [TIME_W-1:0]      last_step;

    t_scroll_view views_due[$];
    t_scroll_view want;
    t_tick        got;
    int           fails;

    // apply one tick word to the shadow state and return the view it leaves
    function automatic t_scroll_view advance_marquee(input t_tick w);
        logic [31:0]  span;
        logic [31:0]  elapsed;
        logic [31:0]  ahead;
        logic [31:0]  next_pos;
        logic         held;
        t_scroll_view v;
        held = 1'b0;
        if (w.text_changed) begin
            pos      = '0;
            running  = 1'b0;
            rev      = 1'b0;
            deadline = w.now_ms + 32'(pause_ms);
        end else if (w.text_width <= view_w) begin
            pos = '0;
        end else begin
            span = 32'(w.text_width) - 32'(view_w);
            if (span > POS_MAX)
                span = POS_MAX;
            // still waiting out the pause at an end
            if (!running) begin
                ahead = w.now_ms - deadline;
                if (ahead[31]) begin
                    held = 1'b1;
                end else begin
                    running   = 1'b1;
                    last_step = w.now_ms;
                end
            end
            elapsed = w.now_ms - last_step;
            if (!held && !elapsed[31] && elapsed >= 32'(interval_ms)) begin
                last_step = w.now_ms;
                if (rev) begin
                    // heading back toward zero
                    if (32'(pos) <= 32'(step_px)) begin
                        pos      = '0;
                        running  = 1'b0;
                        rev      = 1'b0;
                        deadline = w.now_ms + 32'(pause_ms);
                    end else begin
                        pos = pos - OFFSET_BITS'(step_px);
                    end
                end else begin
                    // heading out to the overflow end, clamped there
                    next_pos = 32'(pos) + 32'(step_px);
                    if (next_pos >= span) begin
                        pos      = span[OFFSET_BITS-1:0];
                        running  = 1'b0;
                        rev      = 1'b1;
                        deadline = w.now_ms + 32'(pause_ms);
                    end else begin
                        pos = next_pos[OFFSET_BITS-1:0];
                    end
                end
            end
        end
        v.scroll_offset = OUT_W'(pos);
        v.moving        = running;
        v.backward      = rev;
        return v;
    endfunction

    task automatic report_field(input string field, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            if (fails < REPORT_CAP)
                $display("%0t: %s expected %0d actual %0d", $time, field, exp_val, act_val);
            fails++;
        end
    endtask

    // watch config writes, result words and tick words at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            view_w      = VIEW_WIDTH_RST;
            step_px     = STEP_PIXELS_RST;
            interval_ms = STEP_INTERVAL_RST;
            pause_ms    = END_PAUSE_RST;
            pos         = '0;
            running     = 1'b0;
            rev         = 1'b0;
            deadline    = '0;
            last_step   = '0;
            fails       = 0;
            views_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_VIEW_WIDTH:    view_w      = i_cfg_data[WIDTH_W-1:0];
                    REG_STEP_PIXELS:   step_px     = i_cfg_data[STEP_W-1:0];
                    REG_STEP_INTERVAL: interval_ms = i_cfg_data[MS_W-1:0];
                    REG_END_PAUSE:     pause_ms    = i_cfg_data[MS_W-1:0];
                    default: ;
                endcase
            end
            // result word against the oldest expectation
            if (i_res_mon.valid && i_res_mon.ready) begin
                if (views_due.size() == 0) begin
                    if (fails < REPORT_CAP)
                        $display("%0t: result word with none expected, offset %0d",
                                 $time, i_res_mon.scroll_offset);
                    fails++;
                end else begin
                    want = views_due.pop_front();
                    report_field("scroll_offset", want.scroll_offset, i_res_mon.scroll_offset);
                    report_field("moving", want.moving, i_res_mon.moving);
                    report_field("backward", want.backward, i_res_mon.backward);
                end
            end
            // tick word accepted, predict its view
            if (i_tick_mon.valid && i_tick_mon.ready) begin
                got.now_ms       = i_tick_mon.now_ms;
                got.text_changed = i_tick_mon.text_changed;
                got.text_width   = i_tick_mon.text_width;
                views_due.push_back(advance_marquee(got));
            end
        end
        o_pending    <= views_due.size();
        o_fail_count <= fails;
    end

endmodule

>>> dv/testbench.sv
module testbench;
    import pms_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_SLACK  = 6;
    localparam int LONG_HOLD    = 400;
    localparam int RAND_PHASES  = 8;

    typedef enum int {RX_FLOW, RX_COIN, RX_STINGY} t_rx_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int fail_count;
    int pending;

    pms_tick_if   tick_ch();
    pms_result_if res_ch();

    pingpong_marquee_scroller_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_tick     (tick_ch),
        .o_res      (res_ch)
    );

    marquee_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_tick_mon   (tick_ch),
        .i_res_mon    (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // sender and receiver bookkeeping
    int       burst_left;
    int       hold_left;
    int       stretch_left;
    bit       long_stall_req;
    t_rx_mode rx_mode;
    int       quiet_cycles;

    // generator view of the registers and the text
    int                  gen_view;
    int                  gen_step;
    int                  gen_interval;
    int                  gen_pause;
    logic [TIME_W-1:0]   cur_time;
    logic [WIDTH_W-1:0]  cur_width;
    int                  ph;
    int                  n;
    int                  n_items;

    // offer one tick word, in bursts with random gaps
    task automatic send_tick(input logic [TIME_W-1:0] t, input logic chg,
                             input logic [WIDTH_W-1:0] w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                tick_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        tick_ch.valid        <= 1'b1;
        tick_ch.now_ms       <= t;
        tick_ch.text_changed <= chg;
        tick_ch.text_width   <= w;
        do @(posedge i_clk); while (!tick_ch.ready);
    endtask

    // stop offering and wait until every result word is back
    task automatic drain_results();
        tick_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(val);
        @(posedge i_clk);
    endtask

    task automatic program_regs(input int view, input int step, input int interval,
                                input int pause);
        drain_results();
        write_reg(REG_VIEW_WIDTH, view);
        write_reg(REG_STEP_PIXELS, step);
        write_reg(REG_STEP_INTERVAL, interval);
        write_reg(REG_END_PAUSE, pause);
        i_cfg_we     <= 1'b0;
        gen_view     = view;
        gen_step     = step;
        gen_interval = interval;
        gen_pause    = pause;
    endtask

    // mostly a little wider than the view so both ends get reached
    function automatic logic [WIDTH_W-1:0] pick_width();
        int sel;
        int w;
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
            w = gen_view + $urandom_range(1, 60);
            if (w > 4095)
                w = 4095;
        end else if (sel < 85) begin
            w = $urandom_range(0, 4095);
        end else begin
            w = $urandom_range(0, gen_view > 4095 ? 4095 : gen_view);
        end
        return WIDTH_W'(w);
    endfunction

    // one random tick: time mostly creeps forward, sometimes jumps or slips back
    task automatic random_tick(input bit first);
        int  sel;
        int  span;
        logic chg;
        chg = first;
        sel = $urandom_range(0, 99);
        if (first || sel < 3) begin
            chg = 1'b1;
            cur_width = pick_width();
        end else if (sel < 6) begin
            cur_width = pick_width();
        end
        span = (gen_interval > gen_pause ? gen_interval : gen_pause) / 2 + 2;
        sel = $urandom_range(0, 99);
        if (sel < 2)
            cur_time = $urandom;
        else if (sel < 5)
            cur_time = cur_time - $urandom_range(1, 1000);
        else
            cur_time = cur_time + $urandom_range(0, span);
        send_tick(cur_time, chg, cur_width);
    endtask

    // stimulus
    initial begin
        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_idx            <= REG_VIEW_WIDTH;
        i_cfg_data           <= '0;
        tick_ch.valid        <= 1'b0;
        tick_ch.now_ms       <= '0;
        tick_ch.text_changed <= 1'b0;
        tick_ch.text_width   <= '0;
        burst_left     = 0;
        long_stall_req = 1'b0;
        gen_view       = VIEW_WIDTH_RST;
        gen_step       = STEP_PIXELS_RST;
        gen_interval   = STEP_INTERVAL_RST;
        gen_pause      = END_PAUSE_RST;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // register values after reset: pause, wrap-safe compares, fits, clamp at end
        send_tick(32'd0, 1'b1, 12'd200);
        send_tick(32'd500, 1'b0, 12'd200);
        send_tick(32'hFFFF_FF00, 1'b0, 12'd200);
        send_tick(32'd1000, 1'b0, 12'd200);
        send_tick(32'd1360, 1'b0, 12'd200);
        send_tick(32'd1500, 1'b0, 12'd0);
        send_tick(32'd1720, 1'b0, 12'd4095);
        send_tick(32'd1000, 1'b0, 12'd4095);
        send_tick(32'h8000_0000, 1'b0, 12'd4095);
        send_tick(32'hFFFF_FFFF, 1'b1, 12'd4095);
        send_tick(32'd1, 1'b0, 12'd131);
        send_tick(32'd999, 1'b0, 12'd131);
        send_tick(32'd1359, 1'b0, 12'd131);
        send_tick(32'd2359, 1'b0, 12'd131);
        send_tick(32'd2719, 1'b0, 12'd131);

        // big steps, no waits: stale offset above a narrower overflow gets clamped
        program_regs(1, 255, 0, 0);
        send_tick(32'd10, 1'b1, 12'd4095);
        send_tick(32'd10, 1'b0, 12'd4095);
        send_tick(32'd10, 1'b0, 12'd4095);
        send_tick(32'd11, 1'b0, 12'd300);
        send_tick(32'd12, 1'b0, 12'd300);
        send_tick(32'd13, 1'b0, 12'd4095);
        send_tick(32'd14, 1'b0, 12'd4095);

        // zero view and zero step: offset already at the end still turns around
        program_regs(0, 0, 0, 0);
        send_tick(32'd15, 1'b0, 12'd255);
        send_tick(32'd16, 1'b0, 12'd255);

        // random phases over several register settings
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: program_regs(STEP_PIXELS_RST * 0 + VIEW_WIDTH_RST, STEP_PIXELS_RST,
                                STEP_INTERVAL_RST, END_PAUSE_RST);
                1: program_regs(1, 255, 0, 0);
                2: program_regs(4095, 1, 65535, 65535);
                3: program_regs(0, 0, 7, 3);
                default: program_regs($urandom_range(1, 200), $urandom_range(1, 20),
                                      $urandom_range(0, 50), $urandom_range(0, 80));
            endcase
            if (ph % 2 == 0)
                cur_time = 32'hFFFF_FFFF - $urandom_range(0, 20000);
            else
                cur_time = $urandom;
            n_items = (ph == 3) ? 100 : 220;
            for (n = 0; n < n_items; n++) begin
                if (n == 100 && (ph == 0 || ph == 5))
                    long_stall_req = 1'b1;
                random_tick(n == 0);
            end
        end

        drain_results();
        if (fail_count == 0)
            $display("pingpong_marquee_scroller_unit: match");
        else
            $display("pingpong_marquee_scroller_unit: mismatch");
        $finish;
    end

    // receiver: stretches of free flow, coin flips and heavy stalls, plus long hold-offs
    initial begin
        res_ch.ready <= 1'b0;
        hold_left    = 0;
        stretch_left = 0;
        rx_mode      = RX_FLOW;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else if (long_stall_req) begin
                long_stall_req = 1'b0;
                hold_left = LONG_HOLD;
                res_ch.ready <= 1'b0;
            end else begin
                if (stretch_left == 0) begin
                    stretch_left = $urandom_range(1, 60);
                    rx_mode = t_rx_mode'($urandom_range(0, 2));
                end
                stretch_left--;
                case (rx_mode)
                    RX_FLOW:   res_ch.ready <= 1'b1;
                    RX_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
                    RX_STINGY: res_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:   res_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("pingpong_marquee_scroller_unit: mismatch");
                $finish;
            end
        end
    end

endmodule
